FILE: hdl/ptrm_pkg.sv
package ptrm_pkg;

  localparam int unsigned VaBits     = 48;
  localparam int unsigned PageShift  = 12;
  localparam int unsigned SlotBits   = 9;
  localparam int unsigned LenBits    = 49;
  localparam int unsigned DescBits   = 64;

  localparam logic       CMD_MAP  = 1'b0;
  localparam logic       CMD_READ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] DESC_TABLE = 2'b11;
  localparam logic [1:0] DESC_BLOCK = 2'b01;
  localparam logic [1:0] DESC_PAGE  = 2'b11;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_STEP,
    S_RD,
    S_EVAL,
    S_ZERO,
    S_LINK,
    S_PAGE,
    S_RDCMD,
    S_RDDATA
  } state_e;

endpackage

FILE: hdl/ptrm_req_if.sv
interface ptrm_req_if;
  import ptrm_pkg::*;
  logic        valid;
  logic        ready;
  logic        command;
  logic [47:0] virt_addr;
  logic [47:0] phys_addr;
  logic [48:0] range_length;
  logic [63:0] attr_flags;
  logic [3:0]  read_table;
  logic [8:0]  read_slot;

  modport source (output valid, command, virt_addr, phys_addr, range_length,
                  attr_flags, read_table, read_slot, input ready);
  modport sink   (input valid, command, virt_addr, phys_addr, range_length,
                  attr_flags, read_table, read_slot, output ready);
endinterface

FILE: hdl/ptrm_rsp_if.sv
interface ptrm_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] entry_value;
  logic [4:0]  tables_used;

  modport source (output valid, status, entry_value, tables_used, input ready);
  modport sink   (input valid, status, entry_value, tables_used, output ready);
endinterface

FILE: hdl/page_table_range_mapper_unit.sv
// Page table range mapper: builds 4K-granule, 48-bit, four-level tables in a
// pool of POOL_TABLES tables of 512 descriptors held in one internal memory.
// Channels: req (sink) takes map or read requests, rsp (source) returns one
// result per request (status, entry_value, tables_used). cfg_we_i/cfg_wdata_i
// write the pool base address; write it only while the block is idle.
// After reset a clearing pass zeroes the memory, one entry a cycle, over all
// POOL_TABLES*512 entries; req.ready stays low until it is done.
// Sequence: a read request reads the memory (S_RDCMD) and then registers
// the entry (S_RDDATA). A map request walks the range one step per page or
// block: a start state (S_STEP), a read and an evaluate state (S_RD, S_EVAL)
// per level looked up and a page write (S_PAGE); a 2MB or 1GB block is
// written from S_EVAL. Each new table first gets a clearing sweep (S_ZERO)
// and a link write (S_LINK). One request is in flight at a time.
// The result sits in an output register until rsp.ready; while it is held
// no new request is taken, so a stalled receiver simply stalls the sender.
// Errors (block in the way, table outside the pool, pool exhausted) end the
// walk at once; entries already written stay.
module page_table_range_mapper_unit
  import ptrm_pkg::*;
#(
  parameter int unsigned POOL_TABLES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [47:0] cfg_wdata_i,
  ptrm_req_if.sink    req,
  ptrm_rsp_if.source  rsp
);

  localparam int unsigned TW    = $clog2(POOL_TABLES);
  localparam int unsigned AW    = TW + SlotBits;
  localparam int unsigned Depth = POOL_TABLES * 512;
  localparam int unsigned CW    = TW + 1;

  // descriptor store
  logic [63:0] mem [Depth];
  logic [63:0] rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [63:0]   mem_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_ra];
    end
  end

  state_e        state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [CW-1:0] nf_q, nf_d;
  logic [35:0]   base_q;
  logic [47:0]   va_q, va_d, pa_q, pa_d;
  logic [48:0]   rem_q, rem_d;
  logic [63:0]   flags_q, flags_d;
  logic [TW-1:0] t_q, t_d;
  logic [1:0]    lvl_q, lvl_d;
  logic [3:0]    rtbl_q, rtbl_d;
  logic [8:0]    rslot_q, rslot_d;
  logic          ovld_q, ovld_d;
  logic [1:0]    ostat_q, ostat_d;
  logic [63:0]   oent_q, oent_d;

  logic [8:0]  slot;
  logic [35:0] diff;
  logic        in_pool, aligned;
  logic [48:0] blk_size;

  always_comb begin
    unique case (lvl_q)
      2'd0:    slot = va_q[47:39];
      2'd1:    slot = va_q[38:30];
      2'd2:    slot = va_q[29:21];
      default: slot = va_q[20:12];
    endcase
  end

  // table descriptor -> pool index, modulo 2^48 around the base
  assign diff    = rdata_q[47:12] - base_q;
  assign in_pool = diff < 36'(POOL_TABLES);

  always_comb begin
    if (lvl_q == 2'd1) begin
      aligned  = (va_q[29:0] == 30'd0) && (pa_q[29:0] == 30'd0);
      blk_size = 49'd1 << 30;
    end else begin
      aligned  = (va_q[20:0] == 21'd0) && (pa_q[20:0] == 21'd0);
      blk_size = 49'd1 << 21;
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    nf_d    = nf_q;
    va_d    = va_q;
    pa_d    = pa_q;
    rem_d   = rem_q;
    flags_d = flags_q;
    t_d     = t_q;
    lvl_d   = lvl_q;
    rtbl_d  = rtbl_q;
    rslot_d = rslot_q;
    ovld_d  = ovld_q;
    ostat_d = ostat_q;
    oent_d  = oent_q;
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    mem_wa  = {t_q, slot};
    mem_ra  = {t_q, slot};
    mem_wd  = '0;

    if (ovld_q && rsp.ready) begin
      ovld_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(Depth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid && !ovld_q) begin
          va_d    = req.virt_addr;
          pa_d    = req.phys_addr;
          rem_d   = req.range_length;
          flags_d = req.attr_flags;
          rtbl_d  = req.read_table;
          rslot_d = req.read_slot;
          state_d = (req.command == CMD_READ) ? S_RDCMD : S_STEP;
        end
      end
      S_STEP: begin
        t_d   = '0;
        lvl_d = 2'd0;
        if (rem_q == 49'd0) begin
          ovld_d  = 1'b1;
          ostat_d = ST_OK;
          oent_d  = '0;
          state_d = S_IDLE;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        mem_re  = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        priority if (rdata_q[1:0] == DESC_BLOCK) begin
          ovld_d  = 1'b1;
          ostat_d = ST_BAD;
          oent_d  = '0;
          state_d = S_IDLE;
        end else if (rdata_q[1:0] == DESC_TABLE) begin
          if (!in_pool) begin
            ovld_d  = 1'b1;
            ostat_d = ST_BAD;
            oent_d  = '0;
            state_d = S_IDLE;
          end else begin
            t_d     = diff[TW-1:0];
            lvl_d   = lvl_q + 2'd1;
            state_d = (lvl_q == 2'd2) ? S_PAGE : S_RD;
          end
        end else if (lvl_q != 2'd0 && aligned && rem_q >= blk_size) begin
          mem_we  = 1'b1;
          mem_wd  = {16'd0, pa_q} | flags_q | 64'(DESC_BLOCK);
          va_d    = va_q + blk_size[47:0];
          pa_d    = pa_q + blk_size[47:0];
          rem_d   = rem_q - blk_size;
          state_d = S_STEP;
        end else if (32'(nf_q) >= POOL_TABLES) begin
          ovld_d  = 1'b1;
          ostat_d = ST_FULL;
          oent_d  = '0;
          state_d = S_IDLE;
        end else begin
          clr_d   = '0;
          state_d = S_ZERO;
        end
      end
      S_ZERO: begin
        // clear the table about to be linked in
        mem_we = 1'b1;
        mem_wa = {nf_q[TW-1:0], clr_q[8:0]};
        clr_d  = clr_q + AW'(1);
        if (clr_q[8:0] == 9'h1ff) begin
          state_d = S_LINK;
        end
      end
      S_LINK: begin
        mem_we  = 1'b1;
        mem_wd  = {16'd0, (base_q + 36'(nf_q)), 10'd0, DESC_TABLE};
        t_d     = nf_q[TW-1:0];
        nf_d    = nf_q + CW'(1);
        lvl_d   = lvl_q + 2'd1;
        state_d = (lvl_q == 2'd2) ? S_PAGE : S_RD;
      end
      S_PAGE: begin
        mem_we  = 1'b1;
        mem_wd  = {16'd0, pa_q[47:12], 12'd0} | flags_q | 64'(DESC_PAGE);
        va_d    = va_q + 48'h1000;
        pa_d    = pa_q + 48'h1000;
        rem_d   = (rem_q > 49'h1000) ? rem_q - 49'h1000 : 49'd0;
        state_d = S_STEP;
      end
      S_RDCMD: begin
        mem_re  = 1'b1;
        mem_ra  = {TW'(rtbl_q), rslot_q};
        state_d = S_RDDATA;
      end
      S_RDDATA: begin
        ovld_d  = 1'b1;
        ostat_d = ST_OK;
        oent_d  = (32'(rtbl_q) < POOL_TABLES) ? rdata_q : 64'd0;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      nf_q    <= CW'(1);
      base_q  <= '0;
      ovld_q  <= 1'b0;
      lvl_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      nf_q    <= nf_d;
      ovld_q  <= ovld_d;
      lvl_q   <= lvl_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i[47:12];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    va_q    <= va_d;
    pa_q    <= pa_d;
    rem_q   <= rem_d;
    flags_q <= flags_d;
    t_q     <= t_d;
    rtbl_q  <= rtbl_d;
    rslot_q <= rslot_d;
    ostat_q <= ostat_d;
    oent_q  <= oent_d;
  end

  assign req.ready       = (state_q == S_IDLE) && !ovld_q;
  assign rsp.valid       = ovld_q;
  assign rsp.status      = ostat_q;
  assign rsp.entry_value = oent_q;
  assign rsp.tables_used = 5'(nf_q);

  a_nf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(nf_q) <= POOL_TABLES) else $error("table allocation ran past pool");
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.ready |=> state_q != S_IDLE) else $error("request not started");
  a_no_rsp_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !rsp.valid) else $error("result during clearing pass");

endmodule
